FILE: rtl/core/nearest_timestamp_lookup_defines.svh
`ifndef NEAREST_TIMESTAMP_LOOKUP_DEFINES_SVH
`define NEAREST_TIMESTAMP_LOOKUP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NTL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ntl_pkg.sv
`default_nettype none

package ntl_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned TIME_W          = 63;
  localparam int unsigned INDEX_W         = 10;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_ON  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = CFG_IDX_W'(1);

  typedef struct packed {
    logic clear;
    logic append;
    logic load_query;
    logic rd_mid;
    logic step;
    logic set_idx;
    logic rd_up;
    logic cap_lw;
    logic cap_up;
    logic emit;
  } ntl_cmd_t;

  typedef struct packed {
    logic search_open;
    logic out_free;
  } ntl_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/ntl_datapath.sv
`default_nettype none

module ntl_datapath #(
  parameter int unsigned TABLE_DEPTH = ntl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ntl_pkg::ntl_cmd_t              cmd_i,
  output ntl_pkg::ntl_sts_t              sts_o,
  input  logic [ntl_pkg::TIME_W-1:0]     time_i,
  input  logic                           cfg_valid_i,
  input  logic [ntl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ntl_pkg::TIME_W-1:0]     cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_found_o,
  output logic [ntl_pkg::INDEX_W-1:0]    out_index_o
);
  import ntl_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [TIME_W-1:0] mem_q [TABLE_DEPTH];
  logic [TIME_W-1:0] rdata_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;

  logic [CW-1:0]     count_q, count_d;
  logic [TIME_W-1:0] last_q;
  logic              gap_on_q;
  logic [TIME_W-1:0] max_gap_q;

  logic [TIME_W-1:0] qry_q;
  logic [CW-1:0]     lo_q, hi_q;
  logic [CW-1:0]     mid;
  logic              empty_q;
  logic [AW-1:0]     idx_q;
  logic [CW-1:0]     idx_c;
  logic              has_up_q;
  logic [TIME_W-1:0] lw_q, up_q;
  logic [TIME_W-1:0] gap_c;
  logic              below_c;

  logic              lw_le, up_le, lw_lt_up, found_c;
  logic [AW-1:0]     pick;
  logic [31:0]       pick_w;

  logic              out_valid_q;
  logic              out_found_q;
  logic [INDEX_W-1:0] out_index_q;

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_c   = (lo_q == '0) ? '0 : lo_q - CW'(1);
  assign below_c = rdata_q < qry_q;
  assign gap_c   = (qry_q >= rdata_q) ? (qry_q - rdata_q) : (rdata_q - qry_q);

  assign wr_en = cmd_i.append && (count_q < DEPTH_C) &&
                 ((count_q == '0) || (time_i >= last_q));

  always_comb begin
    if (cmd_i.rd_up) begin
      rd_addr = idx_q + AW'(1);
    end else if (cmd_i.set_idx) begin
      rd_addr = idx_c[AW-1:0];
    end else begin
      rd_addr = mid[AW-1:0];
    end
  end

  // table storage, undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= time_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      gap_on_q  <= 1'b0;
      max_gap_q <= '0;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_GAP_ON:  gap_on_q  <= cfg_data_i[0];
          REG_MAX_GAP: max_gap_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // search and neighbor registers
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      last_q <= time_i;
    end
    if (cmd_i.load_query) begin
      qry_q   <= time_i;
      lo_q    <= '0;
      hi_q    <= count_q;
      empty_q <= (count_q == '0);
    end else if (cmd_i.step) begin
      if (below_c) begin
        lo_q <= mid + CW'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.set_idx) begin
      idx_q    <= idx_c[AW-1:0];
      has_up_q <= (idx_c + CW'(1)) < count_q;
    end
    if (cmd_i.cap_lw) begin
      lw_q <= gap_c;
    end
    if (cmd_i.cap_up) begin
      up_q <= gap_c;
    end
  end

  assign lw_le    = lw_q <= max_gap_q;
  assign up_le    = up_q <= max_gap_q;
  assign lw_lt_up = lw_q < up_q;
  assign found_c  = !empty_q && (!gap_on_q || lw_le || (has_up_q && up_le));
  assign pick     = (has_up_q && !lw_lt_up) ? idx_q + AW'(1) : idx_q;
  assign pick_w   = 32'(pick);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_found_q <= found_c;
      out_index_q <= found_c ? pick_w[INDEX_W-1:0] : '0;
    end
  end

  assign sts_o.search_open = lo_q < hi_q;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_index_o = out_index_q;

endmodule

`default_nettype wire

FILE: rtl/core/ntl_ctrl.sv
`default_nettype none

module ntl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  output logic              in_ready_o,
  input  ntl_pkg::ntl_sts_t sts_i,
  output ntl_pkg::ntl_cmd_t cmd_o
);
  import ntl_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SRCH_RD = 3'd1;
  localparam logic [2:0] ST_SRCH_CMP = 3'd2;
  localparam logic [2:0] ST_NB_LO   = 3'd3;
  localparam logic [2:0] ST_NB_UP   = 3'd4;
  localparam logic [2:0] ST_NB_GAP  = 3'd5;
  localparam logic [2:0] ST_DECIDE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            CMD_CLEAR:  cmd_o.clear = 1'b1;
            CMD_APPEND: cmd_o.append = 1'b1;
            CMD_QUERY: begin
              cmd_o.load_query = 1'b1;
              state_d          = ST_SRCH_RD;
            end
            default: ;
          endcase
        end
      end
      ST_SRCH_RD: begin
        if (sts_i.search_open) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = ST_SRCH_CMP;
        end else begin
          state_d = ST_NB_LO;
        end
      end
      ST_SRCH_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_SRCH_RD;
      end
      ST_NB_LO: begin
        cmd_o.set_idx = 1'b1;
        state_d       = ST_NB_UP;
      end
      ST_NB_UP: begin
        cmd_o.rd_up  = 1'b1;
        cmd_o.cap_lw = 1'b1;
        state_d      = ST_NB_GAP;
      end
      ST_NB_GAP: begin
        cmd_o.cap_up = 1'b1;
        state_d      = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nearest_timestamp_lookup.sv
// clear and append: no result, next request the cycle after
// query: k binary search steps (read mid, compare), k <= ceil(log2(entries+1)),
//   then neighbor reads and gaps, then a decision that waits for a free output
// one request in flight; the search loop over the single table read port sets the rate
// a result waiting in the output register does not block the next request
// reset: entry count, config, output valid and control cleared; table undefined, no sweep
`default_nettype none

module nearest_timestamp_lookup #(
  parameter int unsigned TABLE_DEPTH = ntl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,   // time_value
  input  logic [1:0]                    s_axis_tuser,   // command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // match_index
  output logic                          m_axis_tuser,   // found
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ntl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ntl_pkg::TIME_W-1:0]    cfg_data_i
);
  import ntl_pkg::*;

  ntl_cmd_t           cmd;
  ntl_sts_t           sts;
  logic               out_found;
  logic [INDEX_W-1:0] out_index;

  assign cfg_ready_o = 1'b1;

  ntl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ntl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .time_i      (s_axis_tdata[TIME_W-1:0]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (out_found),
    .out_index_o (out_index)
  );

  assign m_axis_tuser = out_found;
  assign m_axis_tdata = {{(16 - INDEX_W){1'b0}}, out_index};

endmodule

`default_nettype wire

FILE: rtl/core/ntl_checker.sv
`default_nettype none

`include "nearest_timestamp_lookup_defines.svh"

module ntl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import ntl_pkg::*;

  // stalled result holds
  `NTL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // a miss always reports index zero
  `NTL_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'd0, "miss with nonzero index")

  // a query keeps the input side closed while it searches
  `NTL_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY), !s_axis_tready, "request taken during search")

endmodule

bind nearest_timestamp_lookup ntl_checker u_ntl_checker (.*);

`default_nettype wire
